FILE: rtl/jbp_pkg.sv
package jbp_pkg;

  // command codes carried in func
  localparam logic [2:0] FUNC_CODE   = 3'd0;
  localparam logic [2:0] FUNC_BYTE   = 3'd1;
  localparam logic [2:0] FUNC_WORD   = 3'd2;
  localparam logic [2:0] FUNC_MARKER = 3'd3;
  localparam logic [2:0] FUNC_ALIGN  = 3'd4;

  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] BYTE_STUFF = 8'h00;
  localparam logic [4:0] MAX_BITS   = 5'd16;

  // one input word
  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  bit_count;
    logic [15:0] payload;
  } cmd_t;

  // one output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } res_t;

  // all bytes released by one command, first byte in slot 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } bundle_t;

endpackage

FILE: rtl/jbp_front.sv
module jbp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  jbp_pkg::cmd_t    cmd,
  output logic             push,
  output jbp_pkg::bundle_t push_data,
  input  logic             full
);
  import jbp_pkg::*;

  logic [15:0] pend_bits, pend_bits_next;
  logic [3:0]  pend_count, pend_count_next;

  logic [4:0]  nb;
  logic [16:0] mask17;
  logic [15:0] val;
  logic [4:0]  total;
  logic [3:0]  rest;
  logic [15:0] word;
  logic [31:0] val_wide;
  logic [31:0] carry_sh;
  logic [31:0] add_sh;
  logic [15:0] fill_mask;
  logic [15:0] word_al;
  bundle_t     bnd;

  // one byte, followed by a stuffed zero if it is 0xFF
  function automatic bundle_t stuff1(input logic [7:0] b);
    bundle_t r;
    r.bytes = '0;
    r.bytes[0] = b;
    r.bytes[1] = BYTE_STUFF;
    r.count = (b == BYTE_FF) ? 3'd2 : 3'd1;
    return r;
  endfunction

  // high then low byte, each stuffed
  function automatic bundle_t stuff2(input logic [7:0] hi, input logic [7:0] lo);
    bundle_t r;
    r.bytes = '0;
    if (hi == BYTE_FF) begin
      r.bytes[0] = hi;
      r.bytes[1] = BYTE_STUFF;
      r.bytes[2] = lo;
      r.bytes[3] = BYTE_STUFF;
      r.count = (lo == BYTE_FF) ? 3'd4 : 3'd3;
    end else begin
      r.bytes[0] = hi;
      r.bytes[1] = lo;
      r.bytes[2] = BYTE_STUFF;
      r.count = (lo == BYTE_FF) ? 3'd3 : 3'd2;
    end
    return r;
  endfunction

  assign cmd_ready = !full;

  // code bit datapath
  always_comb begin
    nb       = (cmd.bit_count > MAX_BITS) ? MAX_BITS : cmd.bit_count;
    mask17   = (17'd1 << nb) - 17'd1;
    val      = cmd.payload & mask17[15:0];
    total    = {1'b0, pend_count} + nb;
    rest     = total[3:0];
    word     = pend_bits | (val >> rest);
    val_wide = {16'd0, val};
    carry_sh = val_wide << (5'd16 - {1'b0, rest});
    add_sh   = val_wide << (5'd16 - total);
    // align: ones from the held bits down to the next byte boundary
    fill_mask = 16'hFFFF >> pend_count;
    if (pend_count <= 4'd8) begin
      fill_mask[7:0] = 8'h00;
    end
    word_al = pend_bits | fill_mask;
  end

  // classify the command, build its byte bundle and next state
  always_comb begin
    pend_bits_next  = pend_bits;
    pend_count_next = pend_count;
    bnd             = '0;
    case (cmd.func)
      FUNC_CODE: begin
        if (total >= 5'd16) begin
          bnd             = stuff2(word[15:8], word[7:0]);
          pend_count_next = rest;
          pend_bits_next  = carry_sh[15:0];
        end else begin
          pend_bits_next  = pend_bits | add_sh[15:0];
          pend_count_next = total[3:0];
        end
      end
      FUNC_BYTE: begin
        bnd.bytes[0] = cmd.payload[7:0];
        bnd.count    = 3'd1;
      end
      FUNC_WORD: begin
        bnd.bytes[0] = cmd.payload[15:8];
        bnd.bytes[1] = cmd.payload[7:0];
        bnd.count    = 3'd2;
      end
      FUNC_MARKER: begin
        bnd.bytes[0] = BYTE_FF;
        bnd.bytes[1] = cmd.payload[7:0];
        bnd.count    = 3'd2;
      end
      FUNC_ALIGN: begin
        if (pend_count == 4'd0) begin
          bnd = '0;
        end else if (pend_count <= 4'd8) begin
          bnd = stuff1(word_al[15:8]);
        end else begin
          bnd = stuff2(word_al[15:8], word_al[7:0]);
        end
        pend_bits_next  = '0;
        pend_count_next = '0;
      end
      default: begin
        bnd = '0;
      end
    endcase
  end

  assign push      = cmd_valid && cmd_ready && (bnd.count != 3'd0);
  assign push_data = bnd;

  // accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else if (cmd_valid && cmd_ready) begin
      pend_bits  <= pend_bits_next;
      pend_count <= pend_count_next;
    end
  end

endmodule

FILE: rtl/jbp_fifo.sv
module jbp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jbp_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output jbp_pkg::bundle_t pop_data
);
  import jbp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign full     = (fill == FULL_CNT);
  assign avail    = (fill != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/jbp_back.sv
module jbp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             avail,
  input  jbp_pkg::bundle_t pop_data,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output jbp_pkg::res_t    res
);
  import jbp_pkg::*;

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;
  logic       done;

  assign last = ({1'b0, idx} == (cur.count - 3'd1));
  assign done = res_valid && res_ready && last;
  assign pop  = avail && (!cur_valid || done);

  assign res_valid       = cur_valid;
  assign res.out_byte    = cur.bytes[idx];
  assign res.last_of_run = last;

  // bundle being drained
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  // byte index and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (res_valid && res_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

FILE: rtl/jpeg_bit_packer_with_byte_stuffing_core.sv
// A command's bytes are held in the bundle queue, then in the output stage.
// Throughput: at most one command per cycle into a DEPTH-entry bundle queue
// while it is not full; bytes leave at one per cycle while res_ready is high,
// so the single-byte output stage limits the rate of commands that release
// several bytes (up to 4).
// Reset (rst, synchronous): clears held bits, queue and output stage.
module jpeg_bit_packer_with_byte_stuffing_core #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  jbp_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output jbp_pkg::res_t res
);
  import jbp_pkg::*;

  logic    push, full, pop, avail;
  bundle_t push_data, pop_data;

  // accumulator and classification
  jbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // bundle queue
  jbp_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  // byte serializer
  jbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .pop_data  (pop_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
